@@ hw/rtl/hdlcrx_pkg.sv @@
// ---------------------------------------------------------------------------
// hdlcrx_pkg
// shared types and constants of the byte-stuffed frame receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdlcrx_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_FLAG   = 3'd1,
    PH_ADDR   = 3'd2,
    PH_CTRL   = 3'd3,
    PH_SUPCHK = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CHECK   = 3'd1,
    ST_ESC     = 3'd2,
    ST_OVER    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_FLAG        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_ESC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_ESC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SUP_CODES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CODES  = 3'd6;

  localparam int unsigned NUM_SUP_CODES = 7;
  localparam int unsigned LEN_W         = 9;
  localparam logic [LEN_W-1:0] LEN_CAP  = 9'd511;

  localparam logic [7:0]  RST_FLAG       = 8'h7E;
  localparam logic [7:0]  RST_ESCAPE     = 8'h7D;
  localparam logic [7:0]  RST_FLAG_ESC   = 8'h5E;
  localparam logic [7:0]  RST_ESCAPE_ESC = 8'h5D;
  localparam logic [7:0]  RST_ADDRESS    = 8'h03;
  localparam logic [55:0] RST_SUP_CODES  = 56'd36311942822300419;
  localparam logic [15:0] RST_DATA_CODES = 16'h4000;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  flag_escaped_code;
    logic [7:0]  escape_escaped_code;
    logic [7:0]  address_byte;
    logic [55:0] supervisory_codes;
    logic [15:0] data_codes;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic [7:0]       frame_control;
    status_t          frame_status;
    logic [LEN_W-1:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/hdlcrx_frame.sv @@
// ---------------------------------------------------------------------------
// hdlcrx_frame
// frame state machine: header check, inline destuffing, block check
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hdlcrx_frame #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              func,
  input  wire logic [7:0]        rx_byte,
  input  wire hdlcrx_pkg::cfg_t  cfg,
  output logic                   res_valid,
  output hdlcrx_pkg::result_t    res
);

  localparam int unsigned RAW_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [RAW_W-1:0] RAW_MAX  = RAW_W'(MAX_FRAME_BYTES);
  localparam logic [RAW_W-1:0] RAW_OVER = RAW_W'(MAX_FRAME_BYTES + 1);

  hdlcrx_pkg::phase_t         phase_r, phase_nxt;
  logic [7:0]                 ctrl_r, ctrl_nxt;
  logic                       esc_pend_r, esc_pend_nxt;
  logic                       esc_err_r, esc_err_nxt;
  logic                       held_valid_r, held_valid_nxt;
  logic [7:0]                 held_byte_r, held_byte_nxt;
  logic [7:0]                 check_r, check_nxt;
  logic [RAW_W-1:0]           raw_cnt_r, raw_cnt_nxt;
  logic [hdlcrx_pkg::LEN_W-1:0] emit_cnt_r, emit_cnt_nxt;

  logic is_flag;
  logic byte_is_sup;
  logic byte_is_data;
  logic ctrl_is_data;
  logic d_ok;
  logic [7:0] d_byte;
  hdlcrx_pkg::status_t rep_status;
  logic do_report;

  always_comb begin
    byte_is_sup = 1'b0;
    for (int k = 0; k < hdlcrx_pkg::NUM_SUP_CODES; k++) begin
      if (cfg.supervisory_codes[8*k +: 8] == rx_byte) begin
        byte_is_sup = 1'b1;
      end
    end
  end

  assign is_flag      = (rx_byte == cfg.flag_byte);
  assign byte_is_data = (rx_byte == cfg.data_codes[7:0]) || (rx_byte == cfg.data_codes[15:8]);
  assign ctrl_is_data = (ctrl_r == cfg.data_codes[7:0]) || (ctrl_r == cfg.data_codes[15:8]);

  always_comb begin
    phase_nxt      = phase_r;
    ctrl_nxt       = ctrl_r;
    esc_pend_nxt   = esc_pend_r;
    esc_err_nxt    = esc_err_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    check_nxt      = check_r;
    raw_cnt_nxt    = raw_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    res_valid      = 1'b0;
    res            = '0;
    do_report      = 1'b0;
    rep_status     = hdlcrx_pkg::ST_OK;
    d_ok           = 1'b0;
    d_byte         = rx_byte;

    if (func == hdlcrx_pkg::FUNC_TIMEOUT) begin
      do_report  = 1'b1;
      rep_status = hdlcrx_pkg::ST_TIMEOUT;
    end else begin
      unique case (phase_r)
        hdlcrx_pkg::PH_HUNT: begin
          if (is_flag) begin
            phase_nxt = hdlcrx_pkg::PH_FLAG;
          end
        end
        hdlcrx_pkg::PH_FLAG: begin
          if (is_flag) begin
            phase_nxt = hdlcrx_pkg::PH_FLAG;
          end else if (rx_byte == cfg.address_byte) begin
            phase_nxt = hdlcrx_pkg::PH_ADDR;
          end else begin
            phase_nxt = hdlcrx_pkg::PH_HUNT;
          end
        end
        hdlcrx_pkg::PH_ADDR: begin
          if (is_flag) begin
            phase_nxt = hdlcrx_pkg::PH_FLAG;
          end else if (byte_is_sup || byte_is_data) begin
            ctrl_nxt  = rx_byte;
            phase_nxt = hdlcrx_pkg::PH_CTRL;
          end else begin
            phase_nxt = hdlcrx_pkg::PH_HUNT;
          end
        end
        hdlcrx_pkg::PH_CTRL: begin
          if (is_flag) begin
            ctrl_nxt  = '0;
            phase_nxt = hdlcrx_pkg::PH_FLAG;
          end else if (rx_byte == (cfg.address_byte ^ ctrl_r)) begin
            if (ctrl_is_data) begin
              esc_pend_nxt   = 1'b0;
              esc_err_nxt    = 1'b0;
              held_valid_nxt = 1'b0;
              held_byte_nxt  = '0;
              check_nxt      = '0;
              raw_cnt_nxt    = '0;
              emit_cnt_nxt   = '0;
              phase_nxt      = hdlcrx_pkg::PH_DATA;
            end else begin
              phase_nxt = hdlcrx_pkg::PH_SUPCHK;
            end
          end else begin
            ctrl_nxt  = '0;
            phase_nxt = hdlcrx_pkg::PH_HUNT;
          end
        end
        hdlcrx_pkg::PH_SUPCHK: begin
          if (is_flag) begin
            do_report  = 1'b1;
            rep_status = hdlcrx_pkg::ST_OK;
          end else begin
            ctrl_nxt  = '0;
            phase_nxt = hdlcrx_pkg::PH_HUNT;
          end
        end
        hdlcrx_pkg::PH_DATA: begin
          if (is_flag) begin
            do_report = 1'b1;
            if (esc_err_r || esc_pend_r) begin
              rep_status = hdlcrx_pkg::ST_ESC;
            end else if (raw_cnt_r > RAW_MAX) begin
              rep_status = hdlcrx_pkg::ST_OVER;
            end else if (!held_valid_r) begin
              rep_status = hdlcrx_pkg::ST_EMPTY;
            end else if (held_byte_r == check_r) begin
              rep_status = hdlcrx_pkg::ST_OK;
            end else begin
              rep_status = hdlcrx_pkg::ST_CHECK;
            end
          end else if (raw_cnt_r >= RAW_MAX) begin
            raw_cnt_nxt = RAW_OVER;
          end else begin
            raw_cnt_nxt = raw_cnt_r + 1'b1;
            if (!esc_err_r) begin
              if (esc_pend_r) begin
                esc_pend_nxt = 1'b0;
                if (rx_byte == cfg.escape_escaped_code) begin
                  d_byte = cfg.escape_byte;
                  d_ok   = 1'b1;
                end else if (rx_byte == cfg.flag_escaped_code) begin
                  d_byte = cfg.flag_byte;
                  d_ok   = 1'b1;
                end else begin
                  esc_err_nxt = 1'b1;
                end
              end else if (rx_byte == cfg.escape_byte) begin
                esc_pend_nxt = 1'b1;
              end else begin
                d_ok = 1'b1;
              end
            end
          end
        end
        default: begin
          ctrl_nxt       = '0;
          esc_pend_nxt   = 1'b0;
          esc_err_nxt    = 1'b0;
          held_valid_nxt = 1'b0;
          held_byte_nxt  = '0;
          check_nxt      = '0;
          raw_cnt_nxt    = '0;
          emit_cnt_nxt   = '0;
          phase_nxt      = hdlcrx_pkg::PH_HUNT;
        end
      endcase
    end

    if (d_ok) begin
      if (held_valid_r) begin
        res_valid          = 1'b1;
        res.kind           = hdlcrx_pkg::KIND_PAYLOAD;
        res.payload_byte   = held_byte_r;
        res.frame_control  = ctrl_r;
        res.frame_status   = hdlcrx_pkg::ST_OK;
        res.payload_length = '0;
        check_nxt          = check_r ^ held_byte_r;
        if (emit_cnt_r != hdlcrx_pkg::LEN_CAP) begin
          emit_cnt_nxt = emit_cnt_r + 1'b1;
        end
      end
      held_byte_nxt  = d_byte;
      held_valid_nxt = 1'b1;
    end

    if (do_report) begin
      res_valid          = 1'b1;
      res.kind           = hdlcrx_pkg::KIND_REPORT;
      res.payload_byte   = '0;
      res.frame_control  = ctrl_r;
      res.frame_status   = rep_status;
      res.payload_length = emit_cnt_r;
      ctrl_nxt           = '0;
      esc_pend_nxt       = 1'b0;
      esc_err_nxt        = 1'b0;
      held_valid_nxt     = 1'b0;
      held_byte_nxt      = '0;
      check_nxt          = '0;
      raw_cnt_nxt        = '0;
      emit_cnt_nxt       = '0;
      phase_nxt          = hdlcrx_pkg::PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hdlcrx_pkg::PH_HUNT;
      ctrl_r       <= '0;
      esc_pend_r   <= 1'b0;
      esc_err_r    <= 1'b0;
      held_valid_r <= 1'b0;
      held_byte_r  <= '0;
      check_r      <= '0;
      raw_cnt_r    <= '0;
      emit_cnt_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      ctrl_r       <= ctrl_nxt;
      esc_pend_r   <= esc_pend_nxt;
      esc_err_r    <= esc_err_nxt;
      held_valid_r <= held_valid_nxt;
      held_byte_r  <= held_byte_nxt;
      check_r      <= check_nxt;
      raw_cnt_r    <= raw_cnt_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hdlc_frame_receiver_destuffer_core.sv @@
// ---------------------------------------------------------------------------
// hdlc_frame_receiver_destuffer_core
// byte-stuffed frame receiver with inline destuffing and block check
// ---------------------------------------------------------------------------
// takes one line byte or timeout event per transaction and returns at most
// one result per transaction: a destuffed payload byte (released one byte
// late) or a frame completion report. one transaction is accepted every
// cycle while the output is not stalled; a result passes through the input
// register and the result register around the frame logic. configuration
// registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block is idle, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_frame_receiver_destuffer_core #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] payload_byte, [15:8] frame_control,
                                       // [18:16] frame_status, [27:19] payload_length
  output logic             out_tuser,  // [0] kind
  input  wire logic        cfg_we,
  input  wire logic [hdlcrx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hdlcrx_pkg::CFG_DATA_W-1:0] cfg_data
);

  hdlcrx_pkg::cfg_t    cfg_r;
  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_func_r;
  logic                out_valid_r;
  hdlcrx_pkg::result_t out_res_r;
  logic                advance;
  logic                res_valid;
  hdlcrx_pkg::result_t res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte           <= hdlcrx_pkg::RST_FLAG;
      cfg_r.escape_byte         <= hdlcrx_pkg::RST_ESCAPE;
      cfg_r.flag_escaped_code   <= hdlcrx_pkg::RST_FLAG_ESC;
      cfg_r.escape_escaped_code <= hdlcrx_pkg::RST_ESCAPE_ESC;
      cfg_r.address_byte        <= hdlcrx_pkg::RST_ADDRESS;
      cfg_r.supervisory_codes   <= hdlcrx_pkg::RST_SUP_CODES;
      cfg_r.data_codes          <= hdlcrx_pkg::RST_DATA_CODES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdlcrx_pkg::REG_FLAG:       cfg_r.flag_byte           <= cfg_data[7:0];
        hdlcrx_pkg::REG_ESCAPE:     cfg_r.escape_byte         <= cfg_data[7:0];
        hdlcrx_pkg::REG_FLAG_ESC:   cfg_r.flag_escaped_code   <= cfg_data[7:0];
        hdlcrx_pkg::REG_ESCAPE_ESC: cfg_r.escape_escaped_code <= cfg_data[7:0];
        hdlcrx_pkg::REG_ADDRESS:    cfg_r.address_byte        <= cfg_data[7:0];
        hdlcrx_pkg::REG_SUP_CODES:  cfg_r.supervisory_codes   <= cfg_data[55:0];
        hdlcrx_pkg::REG_DATA_CODES: cfg_r.data_codes          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_func_r <= in_tuser;
    end
  end

  hdlcrx_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .func     (in_func_r),
    .rx_byte  (in_byte_r),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {4'd0, out_res_r.payload_length, out_res_r.frame_status,
                       out_res_r.frame_control, out_res_r.payload_byte};

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the byte-stuffed frame receiver
// ---------------------------------------------------------------------------
// line bytes and timeout events go in through a bursty stream driver. A
// bit-accurate frame predictor turns every accepted input transaction into
// the payload bytes and completion reports it must cause. The monitor checks
// each output transaction against the oldest of those, field by field,
// while the output side stalls on a pattern of its own. The run steps through
// the reset setup, a random setup and setups at the edges of the code space.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hdlcrx_pkg::*;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_AT         = 150;
  localparam int HOLD_CYCLES     = 500;
  localparam int MAX_REPORTED    = 10;

  typedef enum int {
    FLAW_NONE,
    FLAW_CHECK,
    FLAW_ESC,
    FLAW_HDR,
    FLAW_TIMEOUT,
    FLAW_EMPTY
  } frame_flaw_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } line_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic        in_tuser = FUNC_BYTE;   // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [7:0] payload_byte, [15:8] frame_control,
                                // [18:16] frame_status, [27:19] payload_length
  logic        out_tuser;       // [0] kind
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hdlc_frame_receiver_destuffer_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state and setup copy
  cfg_t       line_cfg;
  phase_t     rx_phase;
  logic [7:0] cap_ctl;
  logic       esc_pend;
  logic       esc_err;
  logic       held_v;
  logic [7:0] held_b;
  logic [7:0] run_xor;
  int         raw_cnt;
  int         emit_cnt;

  line_item_t line_q[$];
  result_t    frame_results[$];
  result_t    want;
  int         mismatches = 0;
  int         results_seen = 0;
  int         phase_items;

  function automatic bit is_data_ctl(logic [7:0] b);
    return b == line_cfg.data_codes[7:0] || b == line_cfg.data_codes[15:8];
  endfunction

  function automatic bit is_sup_ctl(logic [7:0] b);
    for (int k = 0; k < NUM_SUP_CODES; k++) begin
      if (line_cfg.supervisory_codes[8*k +: 8] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_frame_state();
    cap_ctl  = '0;
    esc_pend = 1'b0;
    esc_err  = 1'b0;
    held_v   = 1'b0;
    held_b   = '0;
    run_xor  = '0;
    raw_cnt  = 0;
    emit_cnt = 0;
  endfunction

  function automatic void close_frame(status_t st);
    result_t r;
    r.kind           = KIND_REPORT;
    r.payload_byte   = '0;
    r.frame_control  = cap_ctl;
    r.frame_status   = st;
    r.payload_length = emit_cnt[LEN_W-1:0];
    frame_results.push_back(r);
    clear_frame_state();
    rx_phase = PH_HUNT;
  endfunction

  function automatic void predict_line_item(logic func, logic [7:0] b);
    logic [7:0] d;
    logic [7:0] c;
    result_t    r;
    if (func == FUNC_TIMEOUT) begin
      close_frame(ST_TIMEOUT);
      return;
    end
    case (rx_phase)
      PH_HUNT: begin
        if (b == line_cfg.flag_byte) rx_phase = PH_FLAG;
      end
      PH_FLAG: begin
        if (b == line_cfg.flag_byte) rx_phase = PH_FLAG;
        else if (b == line_cfg.address_byte) rx_phase = PH_ADDR;
        else rx_phase = PH_HUNT;
      end
      PH_ADDR: begin
        if (b == line_cfg.flag_byte) begin
          rx_phase = PH_FLAG;
        end else if (is_sup_ctl(b) || is_data_ctl(b)) begin
          cap_ctl  = b;
          rx_phase = PH_CTRL;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (b == line_cfg.flag_byte) begin
          cap_ctl  = '0;
          rx_phase = PH_FLAG;
        end else if (b == (line_cfg.address_byte ^ cap_ctl)) begin
          if (is_data_ctl(cap_ctl)) begin
            c = cap_ctl;
            clear_frame_state();
            cap_ctl  = c;
            rx_phase = PH_DATA;
          end else begin
            rx_phase = PH_SUPCHK;
          end
        end else begin
          cap_ctl  = '0;
          rx_phase = PH_HUNT;
        end
      end
      PH_SUPCHK: begin
        if (b == line_cfg.flag_byte) begin
          close_frame(ST_OK);
        end else begin
          cap_ctl  = '0;
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == line_cfg.flag_byte) begin
          if (esc_err || esc_pend) close_frame(ST_ESC);
          else if (raw_cnt > MAX_FRAME_BYTES) close_frame(ST_OVER);
          else if (!held_v) close_frame(ST_EMPTY);
          else if (held_b == run_xor) close_frame(ST_OK);
          else close_frame(ST_CHECK);
          return;
        end
        if (raw_cnt >= MAX_FRAME_BYTES) begin
          raw_cnt = MAX_FRAME_BYTES + 1;
          return;
        end
        raw_cnt++;
        if (esc_err) return;
        if (esc_pend) begin
          esc_pend = 1'b0;
          if (b == line_cfg.escape_escaped_code) begin
            d = line_cfg.escape_byte;
          end else if (b == line_cfg.flag_escaped_code) begin
            d = line_cfg.flag_byte;
          end else begin
            esc_err = 1'b1;
            return;
          end
        end else if (b == line_cfg.escape_byte) begin
          esc_pend = 1'b1;
          return;
        end else begin
          d = b;
        end
        if (held_v) begin
          r.kind           = KIND_PAYLOAD;
          r.payload_byte   = held_b;
          r.frame_control  = cap_ctl;
          r.frame_status   = ST_OK;
          r.payload_length = '0;
          frame_results.push_back(r);
          run_xor = run_xor ^ held_b;
          if (emit_cnt < int'(LEN_CAP)) emit_cnt++;
        end
        held_b = d;
        held_v = 1'b1;
      end
      default: begin
        clear_frame_state();
        rx_phase = PH_HUNT;
      end
    endcase
  endfunction

  // stimulus construction
  function automatic void offer(logic func, logic [7:0] b);
    line_item_t it;
    it.func    = func;
    it.rx_byte = b;
    line_q.push_back(it);
    phase_items++;
  endfunction

  function automatic void offer_byte(logic [7:0] b);
    offer(FUNC_BYTE, b);
  endfunction

  function automatic void offer_stuffed(logic [7:0] b);
    if (b == line_cfg.flag_byte) begin
      offer_byte(line_cfg.escape_byte);
      offer_byte(line_cfg.flag_escaped_code);
    end else if (b == line_cfg.escape_byte) begin
      offer_byte(line_cfg.escape_byte);
      offer_byte(line_cfg.escape_escaped_code);
    end else begin
      offer_byte(b);
    end
  endfunction

  function automatic void queue_data_frame(int n, frame_flaw_t flaw, bit plain);
    logic [7:0] ctl;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hdr;
    int         cut;
    bit         esc_at_end;
    ctl = $urandom_range(0, 1) ? line_cfg.data_codes[15:8] : line_cfg.data_codes[7:0];
    hdr = line_cfg.address_byte ^ ctl;
    if (flaw == FLAW_HDR) hdr = hdr ^ 8'($urandom_range(1, 255));
    sum = '0;
    cut = $urandom_range(0, n);
    esc_at_end = (n == 0) || $urandom_range(0, 1);
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      offer_byte(line_cfg.flag_byte);
    offer_byte(line_cfg.flag_byte);
    offer_byte(line_cfg.address_byte);
    offer_byte(ctl);
    offer_byte(hdr);
    for (int i = 0; i < n; i++) begin
      if (flaw == FLAW_TIMEOUT && i == cut) offer(FUNC_TIMEOUT, 8'($urandom));
      if (flaw == FLAW_ESC && !esc_at_end && i == n / 2) begin
        b = 8'($urandom);
        while (b == line_cfg.flag_escaped_code || b == line_cfg.escape_escaped_code ||
               b == line_cfg.flag_byte)
          b = b + 8'd1;
        offer_byte(line_cfg.escape_byte);
        offer_byte(b);
      end
      case ($urandom_range(0, 99)) inside
        [0:14]:  b = line_cfg.flag_byte;
        [15:29]: b = line_cfg.escape_byte;
        default: b = 8'($urandom);
      endcase
      if (plain) begin
        while (b == line_cfg.flag_byte || b == line_cfg.escape_byte) b = b + 8'd1;
      end
      sum = sum ^ b;
      offer_stuffed(b);
    end
    if (flaw == FLAW_TIMEOUT && cut >= n) offer(FUNC_TIMEOUT, 8'($urandom));
    if (flaw == FLAW_CHECK) sum = sum ^ 8'($urandom_range(1, 255));
    if (flaw != FLAW_EMPTY) offer_stuffed(sum);
    if (flaw == FLAW_ESC && esc_at_end) offer_byte(line_cfg.escape_byte);
    offer_byte(line_cfg.flag_byte);
  endfunction

  function automatic void queue_sup_frame();
    logic [7:0] ctl;
    ctl = line_cfg.supervisory_codes[8*$urandom_range(0, NUM_SUP_CODES-1) +: 8];
    offer_byte(line_cfg.flag_byte);
    offer_byte(line_cfg.address_byte);
    offer_byte(ctl);
    offer_byte(line_cfg.address_byte ^ ctl);
    if ($urandom_range(0, 4) == 0) offer_byte(8'($urandom));
    else offer_byte(line_cfg.flag_byte);
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 99)) inside
      [0:69]:  return $urandom_range(0, 8);
      [70:97]: return $urandom_range(9, 40);
      default: return $urandom_range(250, 262);
    endcase
  endfunction

  function automatic void queue_random_traffic(int target);
    phase_items = 0;
    while (phase_items < target) begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  queue_data_frame(pick_length(), FLAW_NONE, $urandom_range(0, 1));
        [55:64]: queue_sup_frame();
        [65:72]: queue_data_frame($urandom_range(0, 12), FLAW_CHECK, 1'b0);
        [73:78]: queue_data_frame($urandom_range(0, 12), FLAW_ESC, 1'b0);
        [79:83]: queue_data_frame($urandom_range(0, 6), FLAW_HDR, 1'b0);
        [84:87]: queue_data_frame($urandom_range(0, 12), FLAW_TIMEOUT, 1'b0);
        [88:92]: repeat ($urandom_range(1, 6)) offer_byte(8'($urandom));
        [93:96]: queue_data_frame(0, FLAW_EMPTY, 1'b0);
        default: offer(FUNC_TIMEOUT, 8'($urandom));
      endcase
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FLAG:       line_cfg.flag_byte           = val[7:0];
      REG_ESCAPE:     line_cfg.escape_byte         = val[7:0];
      REG_FLAG_ESC:   line_cfg.flag_escaped_code   = val[7:0];
      REG_ESCAPE_ESC: line_cfg.escape_escaped_code = val[7:0];
      REG_ADDRESS:    line_cfg.address_byte        = val[7:0];
      REG_SUP_CODES:  line_cfg.supervisory_codes   = val[55:0];
      REG_DATA_CODES: line_cfg.data_codes          = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [7:0] f, logic [7:0] e, logic [7:0] fe, logic [7:0] ee,
                            logic [7:0] a, logic [55:0] sup, logic [15:0] dc);
    write_reg(REG_FLAG, CFG_DATA_W'(f));
    write_reg(REG_ESCAPE, CFG_DATA_W'(e));
    write_reg(REG_FLAG_ESC, CFG_DATA_W'(fe));
    write_reg(REG_ESCAPE_ESC, CFG_DATA_W'(ee));
    write_reg(REG_ADDRESS, CFG_DATA_W'(a));
    write_reg(REG_SUP_CODES, sup);
    write_reg(REG_DATA_CODES, CFG_DATA_W'(dc));
  endtask

  task automatic load_random_setup();
    logic [7:0] f, e, fe, ee, a;
    f = 8'($urandom);
    e = 8'($urandom);
    while (e == f) e = 8'($urandom);
    fe = 8'($urandom);
    while (fe == f || fe == e) fe = 8'($urandom);
    ee = 8'($urandom);
    while (ee == f || ee == e || ee == fe) ee = 8'($urandom);
    a = 8'($urandom);
    while (a == f) a = 8'($urandom);
    load_setup(f, e, fe, ee, a, {24'($urandom), 32'($urandom)}, 16'($urandom));
  endtask

  task automatic wait_for_drain();
    while (line_q.size() != 0 || frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_line_item(in_tuser, in_tdata);
        line_q.pop_front();
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (line_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= line_q[0].rx_byte;
          in_tuser  <= line_q[0].func;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 300)
                                                    : $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  int  rdy_left = 0;
  int  rdy_pct  = 100;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (rdy_left == 0) begin
          rdy_left = $urandom_range(8, 120);
          case ($urandom_range(0, 3))
            0: rdy_pct = 100;
            1: rdy_pct = 80;
            2: rdy_pct = 50;
            default: rdy_pct = 15;
          endcase
        end
        rdy_left--;
        out_tready <= ($urandom_range(1, 100) <= rdy_pct);
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (frame_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected transaction: tuser %0b tdata %h", out_tuser, out_tdata);
      end else begin
        want = frame_results.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("payload_byte", want.payload_byte, out_tdata[7:0]);
        check_field("frame_control", want.frame_control, out_tdata[15:8]);
        check_field("frame_status", int'(want.frame_status), out_tdata[18:16]);
        check_field("payload_length", want.payload_length, out_tdata[27:19]);
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    line_cfg.flag_byte           = RST_FLAG;
    line_cfg.escape_byte         = RST_ESCAPE;
    line_cfg.flag_escaped_code   = RST_FLAG_ESC;
    line_cfg.escape_escaped_code = RST_ESCAPE_ESC;
    line_cfg.address_byte        = RST_ADDRESS;
    line_cfg.supervisory_codes   = RST_SUP_CODES;
    line_cfg.data_codes          = RST_DATA_CODES;
    rx_phase = PH_HUNT;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames on the reset setup
    phase_items = 0;
    offer(FUNC_TIMEOUT, 8'hFF);
    // resync in the address phase, then both stuffed pairs
    offer_byte(RST_FLAG); offer_byte(RST_ADDRESS); offer_byte(RST_FLAG);
    offer_byte(RST_ADDRESS); offer_byte(8'h40); offer_byte(8'h43);
    offer_byte(8'h7D); offer_byte(8'h5E); offer_byte(8'h7D); offer_byte(8'h5D);
    offer_byte(8'h03); offer_byte(RST_FLAG);
    // empty data field
    offer_byte(RST_FLAG); offer_byte(RST_ADDRESS); offer_byte(8'h00);
    offer_byte(8'h03); offer_byte(RST_FLAG);
    // escape right before the closing flag
    offer_byte(RST_FLAG); offer_byte(RST_ADDRESS); offer_byte(8'h40);
    offer_byte(8'h43); offer_byte(8'h7D); offer_byte(RST_FLAG);
    // supervisory frame
    offer_byte(RST_FLAG); offer_byte(RST_ADDRESS); offer_byte(RST_SUP_CODES[7:0]);
    offer_byte(RST_ADDRESS ^ RST_SUP_CODES[7:0]); offer_byte(RST_FLAG);
    // largest field that fits, then one raw byte too many
    queue_data_frame(255, FLAW_NONE, 1'b1);
    queue_data_frame(256, FLAW_NONE, 1'b1);
    queue_random_traffic(150);
    wait_for_drain();

    load_random_setup();
    queue_random_traffic(300);
    wait_for_drain();

    // low extremes; control 0x00 is in both lists, the other data code is the flag
    load_setup(8'hFF, 8'h00, 8'h01, 8'hFE, 8'h00, 56'h0, 16'hFF00);
    queue_random_traffic(300);
    wait_for_drain();

    // high extremes; flag-escaped code equals the flag
    load_setup(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hFF, {7{8'hFF}}, 16'hFFFF);
    queue_random_traffic(200);
    wait_for_drain();

    load_setup(RST_FLAG, RST_ESCAPE, RST_FLAG_ESC, RST_ESCAPE_ESC, RST_ADDRESS,
               RST_SUP_CODES, RST_DATA_CODES);
    queue_random_traffic(150);
    wait_for_drain();

    if (mismatches == 0 && frame_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
